/* rtl/kclc_pkg.sv */
// Shared types, constants and helpers for the keypad code lock controller.
// No dependencies; every other file in rtl/ uses it by scoped names.
package kclc_pkg;

  localparam int unsigned CodeDigits = 4;
  localparam int unsigned DigitW     = 4;
  localparam int unsigned CodeW      = CodeDigits * DigitW;
  localparam int unsigned KeysW      = 10;
  localparam int unsigned StatusW    = 3;
  localparam int unsigned CountW     = 3;
  localparam int unsigned TriesW     = 3;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned EntryIdxW  = $clog2(CodeDigits);

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgSecretCode = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgTriesLimit = 2'd1;

  localparam logic [CodeW-1:0]  SecretCodeRst = 16'h1123;
  localparam logic [TriesW-1:0] TriesLimitRst = 3'd3;

  // Opcodes of an input word.
  localparam logic OpKey     = 1'b0;
  localparam logic OpContact = 1'b1;

  // Result status codes.
  localparam logic [StatusW-1:0] StDigit     = 3'd0;
  localparam logic [StatusW-1:0] StWrong     = 3'd1;
  localparam logic [StatusW-1:0] StAlarm     = 3'd2;
  localparam logic [StatusW-1:0] StUnlocking = 3'd3;
  localparam logic [StatusW-1:0] StWasOpen   = 3'd4;
  localparam logic [StatusW-1:0] StOpened    = 3'd5;
  localparam logic [StatusW-1:0] StLocked    = 3'd6;
  localparam logic [StatusW-1:0] StIgnored   = 3'd7;

  // Input word after key decode.
  typedef struct packed {
    logic              op;
    logic              key_valid;
    logic [DigitW-1:0] digit;
    logic              closed;
  } item_t;

  // Result word.
  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [CountW-1:0]  digits_entered;
    logic [TriesW-1:0]  tries_left;
    logic               red_led;
    logic               green_led;
    logic               alarm_pulse;
    logic               servo_unlocked;
    logic               finished;
  } result_t;

  // Pipeline handshake between the input stage and the result stage.
  typedef struct packed {
    logic fire;     // input stage word is consumed this cycle
    logic advance;  // result register may load
  } flow_t;

  // Highest pressed digit wins; bit DigitW of the return is the key-present flag.
  function automatic logic [DigitW:0] top_digit(input logic [KeysW-1:0] mask);
    logic [DigitW:0] res;
    res = '0;
    for (int k = 0; k < KeysW; k++) begin
      if (mask[k]) begin
        res = {1'b1, DigitW'(k)};
      end
    end
    return res;
  endfunction

endpackage

/* rtl/kclc_in_stage.sv */
// Input register of the code lock: decodes the key mask and holds one word.
// Depends on kclc_pkg.
module kclc_in_stage (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          opcode_i,
  input  logic [kclc_pkg::KeysW-1:0]    buttons_pressed_i,
  input  logic                          contact_closed_i,
  input  kclc_pkg::flow_t               flow_i,
  output logic                          vld_o,
  output kclc_pkg::item_t               item_o
);

  logic                        vld_q, vld_d;
  kclc_pkg::item_t             item_q;
  logic [kclc_pkg::DigitW:0]   key;
  logic                        take;

  assign key        = kclc_pkg::top_digit(buttons_pressed_i);
  assign in_ready_o = !vld_q || flow_i.advance;
  assign take       = in_valid_i && in_ready_o;

  always_comb begin
    vld_d = vld_q;
    if (take) begin
      vld_d = 1'b1;
    end else if (flow_i.fire) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q.op        <= opcode_i;
      item_q.key_valid <= key[kclc_pkg::DigitW];
      item_q.digit     <= key[kclc_pkg::DigitW-1:0];
      item_q.closed    <= contact_closed_i;
    end
  end

  assign vld_o  = vld_q;
  assign item_o = item_q;

endmodule

/* rtl/kclc_ctrl.sv */
// Lock state, configuration registers and next-state / result logic.
// Depends on kclc_pkg.
module kclc_ctrl (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [kclc_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [kclc_pkg::CodeW-1:0]     cfg_data_i,
  input  kclc_pkg::flow_t                flow_i,
  input  kclc_pkg::item_t                item_i,
  output kclc_pkg::result_t              result_o
);

  localparam logic [1:0] PhEnter     = 2'd0;
  localparam logic [1:0] PhWaitOpen  = 2'd1;
  localparam logic [1:0] PhWaitClose = 2'd2;
  localparam logic [1:0] PhDone      = 2'd3;
  localparam logic [kclc_pkg::EntryIdxW-1:0] LastIdx =
    kclc_pkg::EntryIdxW'(kclc_pkg::CodeDigits - 1);

  logic [kclc_pkg::CodeW-1:0]     code_q;
  logic [kclc_pkg::TriesW-1:0]    limit_q;
  logic [kclc_pkg::DigitW-1:0]    entry_q [kclc_pkg::CodeDigits-1];
  logic [kclc_pkg::EntryIdxW-1:0] cnt_q, cnt_d;
  logic [kclc_pkg::TriesW-1:0]    fail_q, fail_d;
  logic [1:0]                     phase_q, phase_d;
  logic                           red_q, red_d, green_q, green_d, servo_q, servo_d;
  logic                           entry_we;
  logic                           match;
  logic [kclc_pkg::TriesW:0]      fail_inc;
  logic [kclc_pkg::StatusW-1:0]   status;
  logic                           pulse;

  assign match = ({entry_q[0], entry_q[1], entry_q[2], item_i.digit} == code_q);
  assign fail_inc = {1'b0, fail_q} + 1'b1;

  always_comb begin
    cnt_d    = cnt_q;
    fail_d   = fail_q;
    phase_d  = phase_q;
    red_d    = red_q;
    green_d  = green_q;
    servo_d  = servo_q;
    status   = kclc_pkg::StIgnored;
    pulse    = 1'b0;
    entry_we = 1'b0;
    if (phase_q == PhEnter && item_i.op == kclc_pkg::OpKey) begin
      if (item_i.key_valid) begin
        status = kclc_pkg::StDigit;
        if (cnt_q == LastIdx) begin
          cnt_d = '0;
          if (match) begin
            red_d   = 1'b0;
            green_d = 1'b1;
            if (!item_i.closed) begin
              status  = kclc_pkg::StWasOpen;
              pulse   = 1'b1;
              phase_d = PhDone;
            end else begin
              status  = kclc_pkg::StUnlocking;
              servo_d = 1'b1;
              phase_d = PhWaitOpen;
            end
          end else begin
            red_d = 1'b1;
            if (fail_inc > {1'b0, limit_q}) begin
              status = kclc_pkg::StAlarm;
              pulse  = 1'b1;
              fail_d = limit_q;
            end else begin
              status = kclc_pkg::StWrong;
              fail_d = fail_inc[kclc_pkg::TriesW-1:0];
            end
          end
        end else begin
          entry_we = 1'b1;
          cnt_d    = cnt_q + 1'b1;
        end
      end
    end else if (item_i.op == kclc_pkg::OpContact) begin
      if (phase_q == PhWaitOpen && !item_i.closed) begin
        status  = kclc_pkg::StOpened;
        phase_d = PhWaitClose;
      end else if (phase_q == PhWaitClose && item_i.closed) begin
        status  = kclc_pkg::StLocked;
        servo_d = 1'b0;
        phase_d = PhDone;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_q  <= kclc_pkg::SecretCodeRst;
      limit_q <= kclc_pkg::TriesLimitRst;
    end else if (cfg_we_i) begin
      if (cfg_index_i == kclc_pkg::CfgSecretCode) begin
        code_q <= cfg_data_i;
      end else if (cfg_index_i == kclc_pkg::CfgTriesLimit) begin
        limit_q <= cfg_data_i[kclc_pkg::TriesW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      fail_q  <= '0;
      phase_q <= PhEnter;
      red_q   <= 1'b0;
      green_q <= 1'b0;
      servo_q <= 1'b0;
    end else if (flow_i.fire) begin
      cnt_q   <= cnt_d;
      fail_q  <= fail_d;
      phase_q <= phase_d;
      red_q   <= red_d;
      green_q <= green_d;
      servo_q <= servo_d;
    end
  end

  // Entry digits need no reset: each is written before the compare reads it.
  always_ff @(posedge clk_i) begin
    if (flow_i.fire && entry_we) begin
      entry_q[cnt_q] <= item_i.digit;
    end
  end

  always_comb begin
    result_o.status         = status;
    result_o.digits_entered = kclc_pkg::CountW'(cnt_d);
    result_o.tries_left     = (limit_q > fail_d) ? (limit_q - fail_d) : '0;
    result_o.red_led        = red_d;
    result_o.green_led      = green_d;
    result_o.alarm_pulse    = pulse;
    result_o.servo_unlocked = servo_d;
    result_o.finished       = (phase_d == PhDone);
  end

endmodule

/* rtl/kclc_out_stage.sv */
// Result register of the code lock: holds one result word until taken.
// Depends on kclc_pkg.
module kclc_out_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               vld_i,
  input  kclc_pkg::result_t  result_i,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output kclc_pkg::result_t  result_o,
  output kclc_pkg::flow_t    flow_o
);

  logic              vld_q;
  kclc_pkg::result_t res_q;

  assign flow_o.advance = !vld_q || out_ready_i;
  assign flow_o.fire    = vld_i && flow_o.advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (flow_o.advance) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (flow_o.fire) begin
      res_q <= result_i;
    end
  end

  assign out_valid_o = vld_q;
  assign result_o    = res_q;

endmodule

/* rtl/keypad_code_lock_controller_top.sv */
// Top level of the keypad code lock controller: input stage, control, result stage.
// Depends on kclc_pkg, kclc_in_stage, kclc_ctrl and kclc_out_stage.
//
//   Channel  Handshake                 Word
//   -------  ------------------------  ----------------------------------------------
//   in       in_valid_i / in_ready_o   opcode, buttons_pressed, contact_closed
//   out      out_valid_o / out_ready_i status, digits, tries, lamps, pulse, servo, finished
//   cfg      cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i (0 code, 1 tries limit)
//
// Each input word yields exactly one result word: the input register holds the
// word, with the key mask already reduced to a digit, and the control logic then
// loads the result register, which holds the result word until it is taken.
// A new word is accepted every cycle while the result side keeps taking words.
// When out_ready_i is low, the result register holds, the input register
// fills behind it, and in_ready_o drops; no word is lost or repeated.
// Reset clears the lock state and loads the default code and tries limit;
// configuration writes are always taken.
module keypad_code_lock_controller_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // input word channel
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           opcode_i,
  input  logic [kclc_pkg::KeysW-1:0]     buttons_pressed_i,
  input  logic                           contact_closed_i,
  // result word channel
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [kclc_pkg::StatusW-1:0]   status_o,
  output logic [kclc_pkg::CountW-1:0]    digits_entered_o,
  output logic [kclc_pkg::TriesW-1:0]    tries_left_o,
  output logic                           red_led_o,
  output logic                           green_led_o,
  output logic                           alarm_pulse_o,
  output logic                           servo_unlocked_o,
  output logic                           finished_o,
  // configuration channel
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [kclc_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [kclc_pkg::CodeW-1:0]     cfg_data_i
);

  kclc_pkg::flow_t   flow;
  kclc_pkg::item_t   item;
  kclc_pkg::result_t result_d;
  kclc_pkg::result_t result_q;
  logic              item_vld;

  // Registers take a write in any cycle.
  assign cfg_ready_o = 1'b1;

  // Decode the key mask and hold the word.
  kclc_in_stage u_in_stage (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .opcode_i          (opcode_i),
    .buttons_pressed_i (buttons_pressed_i),
    .contact_closed_i  (contact_closed_i),
    .flow_i            (flow),
    .vld_o             (item_vld),
    .item_o            (item)
  );

  // Advance the lock state and form the result word.
  kclc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .flow_i      (flow),
    .item_i      (item),
    .result_o    (result_d)
  );

  // Hold the result until the consumer takes it.
  kclc_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .vld_i       (item_vld),
    .result_i    (result_d),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .result_o    (result_q),
    .flow_o      (flow)
  );

  assign status_o         = result_q.status;
  assign digits_entered_o = result_q.digits_entered;
  assign tries_left_o     = result_q.tries_left;
  assign red_led_o        = result_q.red_led;
  assign green_led_o      = result_q.green_led;
  assign alarm_pulse_o    = result_q.alarm_pulse;
  assign servo_unlocked_o = result_q.servo_unlocked;
  assign finished_o       = result_q.finished;

endmodule

/* verif/keypad_code_lock_controller_top_test.sv */
`timescale 1ns / 1ps
// Self-checking testbench for keypad_code_lock_controller_top: directed and random words,
// predicted in-line and compared at the result port. Depends on kclc_pkg and the RTL top.
module keypad_code_lock_controller_top_test;
  import kclc_pkg::*;

  // Register index past the end of the list; the block must ignore it.
  localparam logic [CfgIdxW-1:0] CfgSpare = 2'd3;

  typedef enum logic [1:0] {
    PhEnter,
    PhWaitOpen,
    PhWaitClose,
    PhDone
  } lock_phase_e;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_ready_o;
  logic                 opcode_i;
  logic [KeysW-1:0]     buttons_pressed_i;
  logic                 contact_closed_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  logic [StatusW-1:0]   status_o;
  logic [CountW-1:0]    digits_entered_o;
  logic [TriesW-1:0]    tries_left_o;
  logic                 red_led_o;
  logic                 green_led_o;
  logic                 alarm_pulse_o;
  logic                 servo_unlocked_o;
  logic                 finished_o;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CfgIdxW-1:0]   cfg_index_i;
  logic [CodeW-1:0]     cfg_data_i;

  keypad_code_lock_controller_top i_dut (.*);

  always #2 clk_i = ~clk_i;

  // Lock state as the block should hold it, plus its two registers.
  logic [DigitW-1:0] held_digits [CodeDigits];
  logic [CountW-1:0] held_count;
  logic [TriesW-1:0] fail_count;
  lock_phase_e       lock_phase;
  logic              red_lamp;
  logic              green_lamp;
  logic              servo_open;
  logic [CodeW-1:0]  code_cfg;
  logic [TriesW-1:0] limit_cfg;

  result_t           lock_results_q [$];
  result_t           due_result;
  int unsigned       mismatch_count = 0;
  int unsigned       words_counted = 0;
  int unsigned       send_idle_pct = 0;
  int unsigned       stall_pct = 0;
  int unsigned       hold_cycles = 0;

  // Advance the lock state by one word and return the result it must produce.
  function automatic result_t predict_lock(input logic op, input logic [KeysW-1:0] mask,
                                           input logic closed);
    result_t     r;
    int          top;
    logic        hit;
    int unsigned tries;
    top = -1;
    for (int k = 0; k < KeysW; k++) begin
      if (mask[k]) top = k;
    end
    r.status = StIgnored;
    r.alarm_pulse = 1'b0;
    if (lock_phase == PhEnter && op == OpKey) begin
      if (top >= 0) begin
        held_digits[held_count[EntryIdxW-1:0]] = DigitW'(top);
        held_count = held_count + 1'b1;
        r.status = StDigit;
        if (held_count >= CodeDigits) begin
          held_count = '0;
          hit = 1'b1;
          for (int i = 0; i < CodeDigits; i++) begin
            if (held_digits[i] != code_cfg[DigitW*(CodeDigits-1-i) +: DigitW]) hit = 1'b0;
          end
          if (hit) begin
            red_lamp = 1'b0;
            green_lamp = 1'b1;
            if (!closed) begin
              // Box already open when the code lands: finish with a buzz.
              r.status = StWasOpen;
              r.alarm_pulse = 1'b1;
              lock_phase = PhDone;
            end else begin
              r.status = StUnlocking;
              servo_open = 1'b1;
              lock_phase = PhWaitOpen;
            end
          end else begin
            tries = fail_count + 1;
            red_lamp = 1'b1;
            if (tries > limit_cfg) begin
              // Past the limit: alarm and hold the count at the limit.
              r.status = StAlarm;
              r.alarm_pulse = 1'b1;
              fail_count = limit_cfg;
            end else begin
              r.status = StWrong;
              fail_count = TriesW'(tries);
            end
          end
        end
      end
    end else if (op == OpContact) begin
      if (lock_phase == PhWaitOpen && !closed) begin
        r.status = StOpened;
        lock_phase = PhWaitClose;
      end else if (lock_phase == PhWaitClose && closed) begin
        r.status = StLocked;
        servo_open = 1'b0;
        lock_phase = PhDone;
      end
    end
    r.digits_entered = held_count;
    r.tries_left = (limit_cfg > fail_count) ? limit_cfg - fail_count : '0;
    r.red_led = red_lamp;
    r.green_led = green_lamp;
    r.servo_unlocked = servo_open;
    r.finished = (lock_phase == PhDone);
    return r;
  endfunction

  // True when digit d would complete the configured code right now.
  function automatic logic completes_code(input logic [DigitW-1:0] d);
    logic hit;
    hit = (lock_phase == PhEnter) && (held_count == CodeDigits - 1);
    for (int i = 0; i < CodeDigits - 1; i++) begin
      if (held_digits[i] != code_cfg[DigitW*(CodeDigits-1-i) +: DigitW]) hit = 1'b0;
    end
    if (d != code_cfg[DigitW-1:0]) hit = 1'b0;
    return hit;
  endfunction

  // Press digit d, with random presses on the lower buttons that must lose.
  function automatic logic [KeysW-1:0] digit_mask(input logic [DigitW-1:0] d);
    logic [KeysW-1:0] one;
    one = KeysW'(1) << d;
    return one | (KeysW'($urandom) & (one - 1'b1));
  endfunction

  function automatic logic [CodeW-1:0] random_bcd();
    logic [CodeW-1:0] c;
    for (int i = 0; i < CodeDigits; i++) begin
      c[DigitW*i +: DigitW] = DigitW'($urandom_range(9));
    end
    return c;
  endfunction

  // Offer one input word, hold it until taken, then log what it must produce.
  task automatic send_word(input logic op, input logic [KeysW-1:0] mask, input logic closed,
                           output logic [StatusW-1:0] st);
    result_t r;
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      // Drop valid and scramble the idle payload.
      in_valid_i <= 1'b0;
      opcode_i <= 1'($urandom);
      buttons_pressed_i <= KeysW'($urandom);
      contact_closed_i <= 1'($urandom);
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i <= op;
    buttons_pressed_i <= mask;
    contact_closed_i <= closed;
    do @(posedge clk_i); while (!in_ready_o);
    r = predict_lock(op, mask, closed);
    lock_results_q.push_back(r);
    if (r.status != StIgnored) words_counted++;
    st = r.status;
  endtask

  // Key word for digit d; nudge it off the code so random traffic never opens the lock.
  task automatic press_digit(input logic [DigitW-1:0] d);
    logic [StatusW-1:0] st;
    logic [DigitW-1:0]  k;
    k = d;
    if (completes_code(k)) k = (k == 4'd9) ? 4'd0 : k + 1'b1;
    send_word(OpKey, digit_mask(k), 1'($urandom), st);
  endtask

  // Drop valid and hold until every logged result has come back.
  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (lock_results_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CodeW-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == CfgSecretCode) begin
      code_cfg = data;
    end else if (idx == CfgTriesLimit) begin
      limit_cfg = data[TriesW-1:0];
    end
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Mostly full attempts close to the code, the rest stray words.
  task automatic random_traffic(input int unsigned n);
    logic [StatusW-1:0] st;
    logic [DigitW-1:0]  want;
    int unsigned        start;
    start = words_counted;
    while (words_counted - start < n) begin
      if ($urandom_range(99) < 80) begin
        for (int i = 0; i < CodeDigits; i++) begin
          want = code_cfg[DigitW*(CodeDigits-1-i) +: DigitW];
          if (want > 4'd9 || $urandom_range(99) < 30) want = DigitW'($urandom_range(9));
          press_digit(want);
        end
      end else begin
        case ($urandom_range(2))
          0: send_word(OpKey, '0, 1'($urandom), st);
          1: send_word(OpContact, KeysW'($urandom), 1'($urandom), st);
          default: press_digit(DigitW'($urandom_range(9)));
        endcase
      end
    end
  endtask

  // Key decode: empty mask, all buttons, lowest button alone, contact while entering.
  task automatic test_key_decode();
    logic [StatusW-1:0] st;
    send_word(OpKey, 10'h000, 1'b1, st);
    send_word(OpKey, 10'h3ff, 1'b0, st);
    send_word(OpContact, 10'h3ff, 1'b1, st);
    send_word(OpKey, 10'h001, 1'b1, st);
    send_word(OpContact, 10'h000, 1'b0, st);
    send_word(OpKey, 10'h155, 1'b0, st);
    send_word(OpKey, 10'h2aa, 1'b1, st);
    wait_drained();
  endtask

  // Failure counting: limit lowered to the count, limit of zero, code
  // with a nibble above nine, an index past the list, and the top limit.
  task automatic test_tries_and_alarm();
    write_reg(CfgTriesLimit, CodeW'(1));
    press_digit(4'd1);
    press_digit(4'd1);
    press_digit(4'd2);
    press_digit(4'd4);
    wait_drained();
    write_reg(CfgSecretCode, 16'h1a23);
    write_reg(CfgTriesLimit, CodeW'(0));
    write_reg(CfgSpare, 16'hffff);
    press_digit(4'd1);
    press_digit(4'd9);
    press_digit(4'd2);
    press_digit(4'd3);
    wait_drained();
    write_reg(CfgTriesLimit, CodeW'(7));
    for (int i = 0; i < CodeDigits; i++) press_digit(4'd0);
    wait_drained();
  endtask

  // Hold the result side off long enough to fill the block and stall the input.
  task automatic test_backpressure();
    send_idle_pct = 0;
    stall_pct = 0;
    hold_cycles = 64;
    random_traffic(40);
    wait_drained();
  endtask

  task automatic test_random_traffic();
    for (int p = 0; p < 4; p++) begin
      wait_drained();
      case (p)
        0: begin
          send_idle_pct = 0;
          stall_pct = 0;
          write_reg(CfgSecretCode, 16'h0000);
          write_reg(CfgTriesLimit, CodeW'(7));
        end
        1: begin
          send_idle_pct = 82;
          stall_pct = 0;
          write_reg(CfgSecretCode, 16'h9999);
          write_reg(CfgTriesLimit, CodeW'(1));
        end
        2: begin
          send_idle_pct = 0;
          stall_pct = 82;
          write_reg(CfgSecretCode, 16'h5a12);
          write_reg(CfgTriesLimit, CodeW'($urandom_range(7, 1)));
        end
        default: begin
          send_idle_pct = 9;
          stall_pct = 9;
          write_reg(CfgSecretCode, random_bcd());
          write_reg(CfgTriesLimit, CodeW'($urandom_range(7, 1)));
        end
      endcase
      random_traffic(360);
    end
    wait_drained();
  endtask

  // Open the lock: either the box is already open when the code lands, or
  // unlock, open, close and relock. Both end the run for the block.
  task automatic test_unlock_sequence();
    logic [StatusW-1:0] st;
    logic [CodeW-1:0]   code;
    logic               was_open;
    code = random_bcd();
    was_open = 1'($urandom);
    send_idle_pct = 30;
    stall_pct = 30;
    write_reg(CfgSecretCode, code);
    write_reg(CfgTriesLimit, CodeW'($urandom_range(7, 1)));
    // Flush any partial attempt left over from random traffic.
    while (held_count != 0) press_digit(DigitW'($urandom_range(9)));
    for (int i = 0; i < CodeDigits; i++) begin
      send_word(OpKey, digit_mask(code[DigitW*(CodeDigits-1-i) +: DigitW]),
                (i == CodeDigits - 1) ? !was_open : 1'($urandom), st);
    end
    if (!was_open) begin
      send_word(OpContact, '0, 1'b1, st);
      send_word(OpKey, digit_mask(4'd5), 1'b0, st);
      send_word(OpContact, '0, 1'b0, st);
      send_word(OpContact, '0, 1'b0, st);
      send_word(OpKey, digit_mask(4'd9), 1'b1, st);
      send_word(OpContact, '0, 1'b1, st);
    end
    // Finished: everything after this must be ignored.
    for (int i = 0; i < 6; i++) begin
      send_word(1'($urandom), KeysW'($urandom), 1'($urandom), st);
    end
  endtask

  // Result side: random stalls, or a counted hold-off when one is requested.
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      mismatch_count++;
      $error("%s: expected %0d, got %0d", name, want, got);
    end
  endtask

  // Compare each taken result word with the oldest logged one.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (lock_results_q.size() == 0) begin
        mismatch_count++;
        $error("result word with none pending: status %0d", status_o);
      end else begin
        due_result = lock_results_q.pop_front();
        check_field("status", due_result.status, status_o);
        check_field("digits_entered", due_result.digits_entered, digits_entered_o);
        check_field("tries_left", due_result.tries_left, tries_left_o);
        check_field("red_led", due_result.red_led, red_led_o);
        check_field("green_led", due_result.green_led, green_led_o);
        check_field("alarm_pulse", due_result.alarm_pulse, alarm_pulse_o);
        check_field("servo_unlocked", due_result.servo_unlocked, servo_unlocked_o);
        check_field("finished", due_result.finished, finished_o);
      end
    end
  end

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    opcode_i = OpKey;
    buttons_pressed_i = '0;
    contact_closed_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CfgSecretCode;
    cfg_data_i = '0;
    for (int i = 0; i < CodeDigits; i++) held_digits[i] = '0;
    held_count = '0;
    fail_count = '0;
    lock_phase = PhEnter;
    red_lamp = 1'b0;
    green_lamp = 1'b0;
    servo_open = 1'b0;
    code_cfg = SecretCodeRst;
    limit_cfg = TriesLimitRst;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_key_decode();
    test_tries_and_alarm();
    test_backpressure();
    test_random_traffic();
    test_unlock_sequence();

    // Let the pipeline settle before the verdict.
    wait_drained();
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("keypad_code_lock_controller_top_test passed");
    end else begin
      $display("keypad_code_lock_controller_top_test failed");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #1_000_000;
    $display("keypad_code_lock_controller_top_test failed");
    $finish;
  end

endmodule
